### rtl/core/deadline_drop_fifo_server_macros.svh
// Assertion macros used by the checker module of the deadline drop FIFO server.
// They rely on clk and arst_n being visible in the scope that uses them.
`ifndef DEADLINE_DROP_FIFO_SERVER_MACROS_SVH
`define DEADLINE_DROP_FIFO_SERVER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define DDFS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define DDFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/ddfs_pkg.sv
// Shared types and constants for the deadline drop FIFO server.
// No dependencies; imported by the top level, the sequencer and the checker.
package ddfs_pkg;

	localparam int ID_W    = 16;
	localparam int TIME_W  = 16;
	localparam int EXP_W   = 7;
	localparam int KIND_W  = 2;
	localparam int ENTRY_W = ID_W + TIME_W;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 40;
	localparam int OUT_USER_W  = 2;

	localparam logic [TIME_W-1:0] TIME_MAX   = '1;
	localparam logic [TIME_W-1:0] TIME_START = TIME_W'(1);
	localparam logic [EXP_W-1:0]  EXP_MAX    = '1;

	// Item kinds carried on the input tuser.
	typedef enum logic [KIND_W-1:0] {
		KIND_ARRIVE = 2'd0,
		KIND_TICK   = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// One result beat, as handed from the sequencer to the output register.
	typedef struct packed {
		logic              served;
		logic [ID_W-1:0]   served_id;
		logic [TIME_W-1:0] served_time;
		logic [EXP_W-1:0]  expired_count;
		logic              overflow;
	} res_t;

endpackage

### rtl/core/deadline_drop_fifo_server.sv
// Deadline drop FIFO server: an arrival, clear or empty-queue tick beat writes its result
// register in the sequencer and then the output register; a tick on a non-empty queue first
// reads the head, then checks head entries, dropping expired ones, until it serves a request
// or the queue is empty. One head entry is checked per cycle by the single read port and deadline
// comparator; a new beat is taken only once the result has moved to the output register.
// Reset clears pointers, count and output valid and sets the time to 1; the store is not cleared.
module deadline_drop_fifo_server #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// request_id [15:0], leave_time [31:16]
	input  logic [ddfs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// kind [1:0]
	input  logic [ddfs_pkg::KIND_W-1:0]       s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// served_id [15:0], served_time [31:16], expired_count [38:32], zero [39]
	output logic [ddfs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// served [0], overflow [1]
	output logic [ddfs_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
	import ddfs_pkg::*;

	logic res_valid;
	logic res_free;
	res_t res;
	logic out_valid_q;
	res_t out_q;

	ddfs_seq #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_id     (s_axis_tdata[ID_W-1:0]),
		.in_leave  (s_axis_tdata[ENTRY_W-1:ID_W]),
		.res_valid (res_valid),
		.res_free  (res_free),
		.res       (res)
	);

	// Output register: free when empty or when its beat leaves this cycle.
	assign res_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q.expired_count, out_q.served_time, out_q.served_id};
	assign m_axis_tuser  = {out_q.overflow, out_q.served};

endmodule

### rtl/core/ddfs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ddfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/core/ddfs_seq.sv
// Sequencer of the deadline drop FIFO server: queue pointers, time counter and
// the shared deadline comparator that walks the head one entry per cycle.
// Depends on ddfs_pkg and ddfs_ram.
module ddfs_seq #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ddfs_pkg::KIND_W-1:0]  in_kind,
	input  logic [ddfs_pkg::ID_W-1:0]    in_id,
	input  logic [ddfs_pkg::TIME_W-1:0]  in_leave,
	output logic                         res_valid,
	input  logic                         res_free,
	output ddfs_pkg::res_t               res
);
	import ddfs_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] ONE_CNT   = CW'(1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CHK  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic [CW-1:0]     count_q;
	logic [TIME_W-1:0] time_q;
	logic [EXP_W-1:0]  exp_q;
	res_t              res_q;

	logic              accept;
	kind_t             kind;
	logic [AW-1:0]     head_nxt;
	logic [AW-1:0]     tail_nxt;
	logic [TIME_W-1:0] time_inc;
	logic [EXP_W-1:0]  exp_inc;
	logic              wr_en;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	logic [ID_W-1:0]   head_id;
	logic [TIME_W-1:0] head_leave;
	logic              head_expired;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign kind      = kind_t'(in_kind);
	assign res_valid = (state_q == ST_EMIT);
	assign res       = res_q;

	// Circular pointer advance and saturating counters.
	assign head_nxt = (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
	assign tail_nxt = (tail_q == LAST_SLOT) ? '0 : tail_q + AW'(1);
	assign time_inc = (time_q == TIME_MAX) ? time_q : time_q + TIME_W'(1);
	assign exp_inc  = (exp_q == EXP_MAX) ? exp_q : exp_q + EXP_W'(1);

	// The shared comparator: is the entry at the head past its deadline?
	assign head_id      = rd_data[ID_W-1:0];
	assign head_leave   = rd_data[ENTRY_W-1:ID_W];
	assign head_expired = (head_leave < time_q);

	// Entry store ports. A tick reads the head; each expiry reads the next one.
	assign wr_en   = accept && (kind == KIND_ARRIVE) && (count_q != FULL_CNT);
	assign rd_addr = (state_q == ST_CHK) ? head_nxt : head_q;
	assign rd_en   = (accept && (kind == KIND_TICK) && (count_q != '0))
		|| ((state_q == ST_CHK) && head_expired && (count_q != ONE_CNT));

	ddfs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data ({in_leave, in_id}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Control sequence and queue state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			time_q  <= TIME_START;
			exp_q   <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						exp_q <= '0;
						unique case (kind)
							KIND_ARRIVE: begin
								res_q <= '{served: 1'b0, served_id: '0, served_time: '0,
									expired_count: '0, overflow: (count_q == FULL_CNT)};
								if (count_q != FULL_CNT) begin
									tail_q  <= tail_nxt;
									count_q <= count_q + ONE_CNT;
								end
								state_q <= ST_EMIT;
							end
							KIND_TICK: begin
								res_q <= '0;
								if (count_q == '0) begin
									time_q  <= time_inc;
									state_q <= ST_EMIT;
								end else begin
									state_q <= ST_CHK;
								end
							end
							KIND_CLEAR: begin
								res_q   <= '0;
								head_q  <= '0;
								tail_q  <= '0;
								count_q <= '0;
								time_q  <= TIME_START;
								state_q <= ST_EMIT;
							end
							default: begin
								res_q   <= '0;
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_CHK: begin
					head_q  <= head_nxt;
					count_q <= count_q - ONE_CNT;
					if (head_expired) begin
						exp_q <= exp_inc;
						if (count_q == ONE_CNT) begin
							// Queue drained by expiries alone.
							res_q <= '{served: 1'b0, served_id: '0, served_time: '0,
								expired_count: exp_inc, overflow: 1'b0};
							time_q  <= time_inc;
							state_q <= ST_EMIT;
						end
					end else begin
						res_q <= '{served: 1'b1, served_id: head_id, served_time: time_q,
							expired_count: exp_q, overflow: 1'b0};
						time_q  <= time_inc;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/core/ddfs_checker.sv
// Port-level checker for the deadline drop FIFO server, bound to the top level.
// Depends on deadline_drop_fifo_server_macros.svh and ddfs_pkg.
`include "deadline_drop_fifo_server_macros.svh"

module ddfs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic [ddfs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input logic [ddfs_pkg::KIND_W-1:0]       s_axis_tuser,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [ddfs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input logic [ddfs_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
	import ddfs_pkg::*;

	// A result beat is held until the sink takes it.
	`DDFS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")

	// A beat never reports both a served request and an overflow.
	`DDFS_ASSERT_NOW(a_serve_ovf, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "served and overflow together")

	// Without a served request the identifier and time fields are zero.
	`DDFS_ASSERT_NOW(a_idle_fields, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[31:0] == 32'd0, "idle serve fields not zero")

	// An overflowing arrival reports no expiries.
	`DDFS_ASSERT_NOW(a_ovf_exp, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata[38:32] == 7'd0, "expiry count on overflow")

	// A stalled result beat keeps its contents.
	`DDFS_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

endmodule

bind deadline_drop_fifo_server ddfs_checker u_ddfs_checker (.*);

### dv/deadline_drop_fifo_server_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the deadline drop FIFO server: drives request, tick and clear
// beats and checks every result beat against its own model of the queue and time counter.
// Depends on ddfs_pkg and the deadline_drop_fifo_server top level.
module deadline_drop_fifo_server_tb;
	import ddfs_pkg::*;

	localparam int DEPTH = 64;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	// Longest tick drains the whole queue, one head entry per cycle.
	localparam int DRAIN_CYCLES = 3 + DEPTH + 20;
	localparam int CYCLE_LIMIT = 2_000_000;

	// Queue and time counter as the block is expected to hold them.
	class ddfs_scoreboard;
		logic [ID_W-1:0]   slot_id    [DEPTH];
		logic [TIME_W-1:0] slot_leave [DEPTH];
		int unsigned       head;
		int unsigned       tail;
		int unsigned       fill;
		logic [TIME_W-1:0] now;
		res_t              pending_q [$];
		int unsigned       errors;
		int unsigned       checked;
		int unsigned       served_n;
		int unsigned       expired_n;
		int unsigned       overflow_n;

		function new();
			clear_state();
			errors = 0;
			checked = 0;
			served_n = 0;
			expired_n = 0;
			overflow_n = 0;
		endfunction

		function void clear_state();
			head = 0;
			tail = 0;
			fill = 0;
			now = TIME_START;
		endfunction

		// Works out the result of one accepted input beat and queues it.
		function void note_beat(logic [KIND_W-1:0] kind, logic [ID_W-1:0] rid,
				logic [TIME_W-1:0] leave);
			res_t r;
			int unsigned h;
			r = '0;
			case (kind)
				KIND_ARRIVE: begin
					if (fill >= DEPTH) begin
						r.overflow = 1'b1;
						overflow_n++;
					end else begin
						slot_id[tail] = rid;
						slot_leave[tail] = leave;
						tail = (tail + 1) % DEPTH;
						fill++;
					end
				end
				KIND_TICK: begin
					h = head;
					// Drop heads whose deadline has already passed.
					while (fill > 0 && slot_leave[h] < now) begin
						h = (h + 1) % DEPTH;
						fill--;
						if (r.expired_count != EXP_MAX)
							r.expired_count = r.expired_count + 1'b1;
					end
					if (fill > 0) begin
						r.served = 1'b1;
						r.served_id = slot_id[h];
						r.served_time = now;
						h = (h + 1) % DEPTH;
						fill--;
						served_n++;
					end
					expired_n += r.expired_count;
					head = h;
					if (now != TIME_MAX)
						now = now + 1'b1;
				end
				KIND_CLEAR: begin
					clear_state();
				end
				default: begin
				end
			endcase
			pending_q.push_back(r);
		endfunction

		// Compares one accepted result beat with the oldest expectation.
		function void check_beat(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
			res_t got;
			res_t want;
			got.served = user[0];
			got.overflow = user[1];
			got.served_id = data[15:0];
			got.served_time = data[31:16];
			got.expired_count = data[38:32];
			checked++;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: result beat with nothing pending: tdata=%h tuser=%b",
						data, user);
				return;
			end
			want = pending_q.pop_front();
			if (got.served !== want.served || got.served_id !== want.served_id ||
					got.served_time !== want.served_time ||
					got.expired_count !== want.expired_count ||
					got.overflow !== want.overflow || data[39] !== 1'b0) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: result %0d expected: served %b id %h time %h expired %0d ovf %b",
						checked, want.served, want.served_id, want.served_time,
						want.expired_count, want.overflow);
					$display("ERROR: result %0d actual:   served %b id %h time %h expired %0d ovf %b pad %b",
						checked, got.served, got.served_id, got.served_time,
						got.expired_count, got.overflow, data[39]);
				end
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic [KIND_W-1:0]      s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic [OUT_USER_W-1:0]  m_axis_tuser;

	ddfs_scoreboard sb;
	int unsigned src_idle = 0;
	int unsigned sink_stall = 0;
	int unsigned beats_sent = 0;
	int unsigned cycle_count = 0;
	logic        hold_req = 1'b0;
	logic        hold_active = 1'b0;
	int unsigned hold_count;

	deadline_drop_fifo_server #(
		.QUEUE_DEPTH(DEPTH)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// Run limit in case the block stops answering.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d results pending", cycle_count,
				sb.pending_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result side: check each accepted beat, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_beat(m_axis_tdata, m_axis_tuser);
		if (hold_active)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= sink_stall);
	end

	// Long receiver hold-off so that results back up and the input stalls.
	initial begin
		wait (hold_req);
		@(posedge clk);
		hold_active <= 1'b1;
		for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
			@(posedge clk);
		hold_active <= 1'b0;
	end

	// Offers one input beat, with random idle cycles ahead of it, and waits for acceptance.
	task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] rid,
			input logic [TIME_W-1:0] leave);
		while ($urandom_range(0, 99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {leave, rid};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_beat(kind, rid, leave);
		if (kind != KIND_UNUSED)
			beats_sent++;
	endtask

	// Deadline between lo and hi ticks from the current time, clamped to the field range.
	function automatic logic [TIME_W-1:0] near_deadline(int lo, int hi);
		int lt;
		lt = int'(sb.now) + lo + int'($urandom_range(0, hi - lo));
		if (lt < 0)
			lt = 0;
		if (lt > int'(TIME_MAX))
			lt = int'(TIME_MAX);
		return TIME_W'(lt);
	endfunction

	// Random traffic: mostly arrival bursts followed by ticks, some clears and noise.
	task automatic run_phase(input int unsigned count);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned n;
		stop_at = beats_sent + count;
		while (beats_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				n = $urandom_range(1, 8);
				repeat (n) send_beat(KIND_ARRIVE, ID_W'($urandom), near_deadline(-3, 12));
				n = $urandom_range(1, 6);
				repeat (n) send_beat(KIND_TICK, ID_W'($urandom), TIME_W'($urandom));
			end else if (pick < 55) begin
				// Entries that go stale together, so one tick drops several heads.
				n = $urandom_range(2, 12);
				repeat (n) send_beat(KIND_ARRIVE, ID_W'($urandom), near_deadline(-1, 1));
				repeat (3) send_beat(KIND_TICK, '0, '0);
			end else if (pick < 62) begin
				n = $urandom_range(50, 70);
				repeat (n) send_beat(KIND_ARRIVE, ID_W'($urandom), near_deadline(0, 200));
				n = $urandom_range(1, 4);
				repeat (n) send_beat(KIND_TICK, '0, '0);
			end else if (pick < 70) begin
				send_beat(KIND_CLEAR, ID_W'($urandom), TIME_W'($urandom));
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) send_beat(KIND_W'($urandom_range(0, 3)), ID_W'($urandom),
					TIME_W'($urandom));
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty tick, unused kind, field extremes, expiry and clear.
		send_beat(KIND_TICK, '0, '0);
		send_beat(KIND_UNUSED, '0, '0);
		send_beat(KIND_ARRIVE, '0, '0);
		send_beat(KIND_ARRIVE, '1, '1);
		send_beat(KIND_ARRIVE, 16'h1234, 16'd1);
		send_beat(KIND_TICK, '0, '0);
		send_beat(KIND_TICK, '0, '0);
		send_beat(KIND_ARRIVE, 16'h5555, 16'd5);
		send_beat(KIND_ARRIVE, 16'haaaa, 16'd2);
		send_beat(KIND_CLEAR, '1, '1);
		send_beat(KIND_ARRIVE, 16'h00ff, 16'd1);
		send_beat(KIND_TICK, '1, '1);
		send_beat(KIND_TICK, '0, '0);
		send_beat(KIND_ARRIVE, 16'hff00, 16'd3);
		send_beat(KIND_ARRIVE, 16'h0f0f, 16'd3);
		send_beat(KIND_ARRIVE, 16'hf0f0, 16'd4);
		send_beat(KIND_TICK, '0, '0);
		send_beat(KIND_TICK, '0, '0);
		send_beat(KIND_UNUSED, '1, '1);
		send_beat(KIND_TICK, '0, '0);
		send_beat(KIND_CLEAR, '0, '0);

		// Deadlines at the top of the field range.
		send_beat(KIND_ARRIVE, 16'hbeef, TIME_MAX);
		send_beat(KIND_ARRIVE, 16'hdead, TIME_MAX - 1'b1);
		send_beat(KIND_ARRIVE, 16'hcafe, TIME_MAX);
		send_beat(KIND_TICK, '0, '0);
		send_beat(KIND_TICK, '0, '0);
		send_beat(KIND_TICK, '0, '0);
		send_beat(KIND_CLEAR, '0, '0);

		// Receiver held off while arrivals keep coming, overrunning the queue.
		hold_req = 1'b1;
		repeat (DEPTH + 6) send_beat(KIND_ARRIVE, ID_W'($urandom), near_deadline(0, 400));
		repeat (4) send_beat(KIND_TICK, '0, '0);

		run_phase(125);
		src_idle = 55;
		sink_stall = 0;
		run_phase(125);
		src_idle = 0;
		sink_stall = 55;
		run_phase(125);
		src_idle = 14;
		sink_stall = 14;
		run_phase(125);

		s_axis_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d beats, checked %0d results: %0d served, %0d expired, %0d overflows.",
			beats_sent, sb.checked, sb.served_n, sb.expired_n, sb.overflow_n);
		$display("Covered edge deadlines, queue overrun under a long output hold-off and four idle mixes.");
		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches in total", sb.errors);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
